### design/ktr_pkg.sv
// ----------------------------------------------------------------------------
// ktr_pkg
// Shared types and constants of the typematic repeat block: the slot record
// that travels around the cell ring, the register set and the sequencer codes.
// ----------------------------------------------------------------------------
package ktr_pkg;

    localparam int KEY_W      = 10;
    localparam int CNT_W      = 16;
    localparam int OP_W       = 2;
    localparam int DATA_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int SLOTS_DEF     = 16;
    localparam int KEY_LIMIT_DEF = 780;

    localparam logic [CNT_W-1:0] DELAY_RST    = 16'd300;
    localparam logic [CNT_W-1:0] PERIOD_RST   = 16'd33;
    localparam logic [KEY_W-1:0] EXCLUDED_RST = 10'd1023;

    typedef enum logic [OP_W-1:0] {
        OP_KEY_DOWN   = 2'd0,
        OP_KEY_UP     = 2'd1,
        OP_FOCUS_LOST = 2'd2,
        OP_TICK       = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELAY  = 3'd0,
        CFG_PERIOD = 3'd1,
        CFG_EXCL_A = 3'd2,
        CFG_EXCL_B = 3'd3,
        CFG_EXCL_C = 3'd4,
        CFG_EXCL_D = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic             used;
        logic             repeating;
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] countdown;
    } slot_t;

    typedef struct packed {
        logic [CNT_W-1:0] delay_ticks;
        logic [CNT_W-1:0] period_ticks;
        logic [KEY_W-1:0] excluded_a;
        logic [KEY_W-1:0] excluded_b;
        logic [KEY_W-1:0] excluded_c;
        logic [KEY_W-1:0] excluded_d;
    } cfg_t;

endpackage

### design/key_typematic_repeat.sv
// ----------------------------------------------------------------------------
// key_typematic_repeat
// Per-key typematic repeat over a ring of slot cells.
// ----------------------------------------------------------------------------
// Input words (s_ channel) carry an event kind in s_tuser: key down, key up,
// focus lost or a timer tick, with the key code in s_tdata. A key down of an
// allowed key starts its delay in a free slot; when the delay runs out the key
// repeats once per period. Each tick gives one m_ word per repeat that fires,
// in slot order, with m_tlast on the final one; other events give no output.
// The cfg channel writes the delay, the period and four excluded key codes;
// it is always ready and must only be used while the block is idle.
// Every event rotates the whole slot ring once past a single processing
// stage, one slot per cycle while the output does not stall the walk, then
// passes a closing state: after a word is accepted s_tready stays low until
// the block is back in idle, so a new input word waits for the whole walk.
// Each repeat is held back one word so the final one can carry m_tlast: it
// moves from the held register to the output register when the next repeat
// of the tick is taken at the head of the ring, or in the closing state for
// the final one. If the receiver stalls, the walk pauses when a new repeat
// must push the held word into an output register that is still full, and
// the closing state waits the same way.
// Reset clears every slot and loads the register defaults; no sweep is needed.
// ----------------------------------------------------------------------------
module key_typematic_repeat
    import ktr_pkg::*;
#(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int KEY_LIMIT = KEY_LIMIT_DEF
)(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [DATA_W-1:0]     s_tdata,    // [9:0] key_code, [15:10] zero
    input  logic [OP_W-1:0]       s_tuser,    // [1:0] opcode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [DATA_W-1:0]     m_tdata,    // [9:0] repeat_key, [15:10] zero
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t             cfg_reg, cfg_next;
    slot_t            ring [SLOTS];
    slot_t            tail;
    slot_t            alloc_rec;
    logic             shift_en;
    logic [SLOTS-1:0] alloc_we;
    logic [KEY_W-1:0] m_key;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_DELAY:  cfg_next.delay_ticks  = cfg_data;
                CFG_PERIOD: cfg_next.period_ticks = cfg_data;
                CFG_EXCL_A: cfg_next.excluded_a   = cfg_data[KEY_W-1:0];
                CFG_EXCL_B: cfg_next.excluded_b   = cfg_data[KEY_W-1:0];
                CFG_EXCL_C: cfg_next.excluded_c   = cfg_data[KEY_W-1:0];
                CFG_EXCL_D: cfg_next.excluded_d   = cfg_data[KEY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{delay_ticks: DELAY_RST, period_ticks: PERIOD_RST,
                         excluded_a: EXCLUDED_RST, excluded_b: EXCLUDED_RST,
                         excluded_c: EXCLUDED_RST, excluded_d: EXCLUDED_RST};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // slot i hands its record to slot i-1; slot 0 is the head
    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        slot_t din;
        if (i == SLOTS - 1) begin : g_tail
            assign din = tail;
        end else begin : g_mid
            assign din = ring[i+1];
        end
        ktr_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (shift_en),
            .din      (din),
            .wr_en    (alloc_we[i]),
            .wr_rec   (alloc_rec),
            .dout     (ring[i])
        );
    end

    ktr_ctrl #(
        .SLOTS     (SLOTS),
        .KEY_LIMIT (KEY_LIMIT)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_op      (s_tuser),
        .s_key     (s_tdata[KEY_W-1:0]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_key     (m_key),
        .m_last    (m_tlast),
        .head      (ring[0]),
        .shift_en  (shift_en),
        .tail      (tail),
        .alloc_we  (alloc_we),
        .alloc_rec (alloc_rec)
    );

    assign m_tdata = {{(DATA_W - KEY_W){1'b0}}, m_key};

endmodule

### design/ktr_cell.sv
// ----------------------------------------------------------------------------
// ktr_cell
// One slot of the key table. Takes the record of its upstream neighbor when
// the ring rotates, or a freshly allocated record on a direct write.
// ----------------------------------------------------------------------------
module ktr_cell
    import ktr_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  shift_en,
    input  slot_t din,
    input  logic  wr_en,
    input  slot_t wr_rec,
    output slot_t dout
);

    logic             used_reg,  used_next;
    logic             rep_reg,   rep_next;
    logic [KEY_W-1:0] key_reg,   key_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;

    always_comb begin
        used_next = used_reg;
        rep_next  = rep_reg;
        key_next  = key_reg;
        cnt_next  = cnt_reg;
        if (wr_en) begin
            used_next = wr_rec.used;
            rep_next  = wr_rec.repeating;
            key_next  = wr_rec.key;
            cnt_next  = wr_rec.countdown;
        end else if (shift_en) begin
            used_next = din.used;
            rep_next  = din.repeating;
            key_next  = din.key;
            cnt_next  = din.countdown;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= 1'b0;
            rep_reg  <= 1'b0;
        end else begin
            used_reg <= used_next;
            rep_reg  <= rep_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        cnt_reg <= cnt_next;
    end

    assign dout = '{used: used_reg, repeating: rep_reg, key: key_reg, countdown: cnt_reg};

endmodule

### design/ktr_ctrl.sv
// ----------------------------------------------------------------------------
// ktr_ctrl
// Sequencer and slot processor. Walks the ring once per word, updating the
// record at the head and feeding it back at the tail, and drives the result
// stage with a one-word lookahead so the final repeat of a tick gets tlast.
// ----------------------------------------------------------------------------
module ktr_ctrl
    import ktr_pkg::*;
#(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int KEY_LIMIT = KEY_LIMIT_DEF
)(
    input  logic             aclk,
    input  logic             aresetn,
    input  cfg_t             cfg,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [OP_W-1:0]  s_op,
    input  logic [KEY_W-1:0] s_key,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [KEY_W-1:0] m_key,
    output logic             m_last,
    input  slot_t            head,
    output logic             shift_en,
    output slot_t            tail,
    output logic [SLOTS-1:0] alloc_we,
    output slot_t            alloc_rec
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_STEP = SLOT_W'(SLOTS - 1);

    state_t            state_reg, state_next;
    logic [SLOT_W-1:0] step_reg, step_next;
    op_t               op_reg, op_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic              allowed_reg, allowed_next;
    logic              found_reg, found_next;
    logic              free_found_reg, free_found_next;
    logic [SLOT_W-1:0] free_idx_reg, free_idx_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [KEY_W-1:0]  pend_key_reg, pend_key_next;
    logic              out_valid_reg, out_valid_next;
    logic [KEY_W-1:0]  out_key_reg, out_key_next;
    logic              out_last_reg, out_last_next;

    logic  in_allowed;
    logic  match;
    logic  emit;
    logic  out_free;
    logic  alloc;
    slot_t proc;

    assign in_allowed = ({1'b0, s_key} < (KEY_W + 1)'(KEY_LIMIT))
                     && s_key != cfg.excluded_a && s_key != cfg.excluded_b
                     && s_key != cfg.excluded_c && s_key != cfg.excluded_d;

    assign match    = head.used && head.key == key_reg;
    assign out_free = !out_valid_reg || m_tready;

    // per-slot update of the record at the head of the ring
    always_comb begin
        proc = head;
        emit = 1'b0;
        unique case (op_reg)
            OP_KEY_DOWN: begin
                if (allowed_reg && match && !head.repeating) begin
                    proc.countdown = cfg.delay_ticks;
                end
            end
            OP_KEY_UP: begin
                if (match) begin
                    proc.used      = 1'b0;
                    proc.repeating = 1'b0;
                end
            end
            OP_FOCUS_LOST: begin
                proc.used      = 1'b0;
                proc.repeating = 1'b0;
            end
            OP_TICK: begin
                if (head.used) begin
                    if (head.countdown > CNT_W'(1)) begin
                        proc.countdown = head.countdown - CNT_W'(1);
                    end else begin
                        proc.countdown = cfg.period_ticks;
                        proc.repeating = 1'b1;
                        emit           = head.repeating;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign alloc = state_reg == ST_FINISH && op_reg == OP_KEY_DOWN && allowed_reg
                && !found_reg && free_found_reg;

    assign alloc_rec = '{used: 1'b1, repeating: 1'b0, key: key_reg,
                         countdown: cfg.delay_ticks};

    for (genvar i = 0; i < SLOTS; i++) begin : g_we
        assign alloc_we[i] = alloc && free_idx_reg == SLOT_W'(i);
    end

    assign tail = proc;

    always_comb begin
        state_next      = state_reg;
        step_next       = step_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        allowed_next    = allowed_reg;
        found_next      = found_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_key_next   = pend_key_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_key_next    = out_key_reg;
        out_last_next   = out_last_reg;
        shift_en        = 1'b0;
        s_tready        = state_reg == ST_IDLE;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next         = op_t'(s_op);
                    key_next        = s_key;
                    allowed_next    = in_allowed;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    step_next       = '0;
                    state_next      = ST_WALK;
                end
            end
            ST_WALK: begin
                // a new repeat pushes the held one out; wait if the stage is full
                if (!(emit && pend_valid_reg && !out_free)) begin
                    shift_en  = 1'b1;
                    step_next = step_reg + SLOT_W'(1);
                    if (match) begin
                        found_next = 1'b1;
                    end
                    if (!head.used && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_idx_next   = step_reg;
                    end
                    if (emit) begin
                        if (pend_valid_reg) begin
                            out_valid_next = 1'b1;
                            out_key_next   = pend_key_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_key_next   = head.key;
                    end
                    if (step_reg == LAST_STEP) begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_key_next    = pend_key_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg       <= step_next;
        op_reg         <= op_next;
        key_reg        <= key_next;
        allowed_reg    <= allowed_next;
        found_reg      <= found_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        pend_key_reg   <= pend_key_next;
        out_key_reg    <= out_key_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_key    = out_key_reg;
    assign m_last   = out_last_reg;

endmodule

### design/ktr_checker.sv
// ----------------------------------------------------------------------------
// ktr_checker
// Port-level checks of the typematic repeat block, bound to the top level.
// ----------------------------------------------------------------------------
module ktr_checker
    import ktr_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata,
    input logic              m_tlast,
    input logic              cfg_ready
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    // one event at a time: the walk blocks the input for the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an accepted word");

    // reset leaves the block idle with no result pending
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready && cfg_ready)
        else $error("block not idle after reset");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[DATA_W-1:KEY_W] == '0)
        else $error("result padding bits not zero");

endmodule

bind key_typematic_repeat ktr_checker u_ktr_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_ready (cfg_ready)
);

### dv/key_typematic_repeat_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// key_typematic_repeat_tb
// Self-checking bench for the per-key typematic repeat block: a scripted
// opening of key downs, key ups, focus losses and ticks, then random event
// streams under several delay, period and excluded-key settings. Every repeat
// word is checked against a typed script row or a slot-table model in the bench.
// ----------------------------------------------------------------------------
module key_typematic_repeat_tb;
    import ktr_pkg::*;

    localparam int SETTLE         = 2 * (SLOTS_DEF + 1) + 8;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int ROWS           = 27;
    localparam int DEFAULT_ROWS   = 5;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             last;
    } rep_t;

    typedef struct packed {
        op_t              op;
        logic [KEY_W-1:0] key;
        logic             typed;
        logic [1:0]       n;
        logic [KEY_W-1:0] k0;
        logic [KEY_W-1:0] k1;
    } row_t;

    // typed rows carry the repeat words directly, the rest go through the model
    localparam row_t SCRIPT [ROWS] = '{
        '{OP_KEY_DOWN,   10'd5,   1'b1, 2'd0, 10'd0,   10'd0},
        '{OP_TICK,       10'd0,   1'b1, 2'd0, 10'd0,   10'd0},
        '{OP_KEY_UP,     10'd5,   1'b1, 2'd0, 10'd0,   10'd0},
        '{OP_KEY_DOWN,   10'd6,   1'b0, 2'd0, 10'd0,   10'd0},
        '{OP_FOCUS_LOST, 10'd0,   1'b1, 2'd0, 10'd0,   10'd0},
        '{OP_KEY_DOWN,   10'd0,   1'b1, 2'd0, 10'd0,   10'd0},
        '{OP_KEY_DOWN,   10'd779, 1'b1, 2'd0, 10'd0,   10'd0},
        '{OP_KEY_DOWN,   10'd780, 1'b1, 2'd0, 10'd0,   10'd0},
        '{OP_KEY_DOWN,   10'd500, 1'b1, 2'd0, 10'd0,   10'd0},
        '{OP_KEY_DOWN,   10'd778, 1'b1, 2'd0, 10'd0,   10'd0},
        '{OP_TICK,       10'd0,   1'b1, 2'd0, 10'd0,   10'd0},
        '{OP_TICK,       10'd0,   1'b1, 2'd0, 10'd0,   10'd0},
        '{OP_TICK,       10'd0,   1'b1, 2'd1, 10'd778, 10'd0},
        '{OP_KEY_DOWN,   10'd778, 1'b1, 2'd0, 10'd0,   10'd0},
        '{OP_KEY_DOWN,   10'd1,   1'b1, 2'd0, 10'd0,   10'd0},
        '{OP_TICK,       10'd0,   1'b1, 2'd1, 10'd778, 10'd0},
        '{OP_KEY_DOWN,   10'd1,   1'b1, 2'd0, 10'd0,   10'd0},
        '{OP_TICK,       10'd0,   1'b1, 2'd1, 10'd778, 10'd0},
        '{OP_TICK,       10'd0,   1'b1, 2'd1, 10'd778, 10'd0},
        '{OP_TICK,       10'd0,   1'b1, 2'd2, 10'd778, 10'd1},
        '{OP_KEY_UP,     10'd778, 1'b1, 2'd0, 10'd0,   10'd0},
        '{OP_TICK,       10'd0,   1'b1, 2'd1, 10'd1,   10'd0},
        '{OP_KEY_DOWN,   10'd1,   1'b1, 2'd0, 10'd0,   10'd0},
        '{OP_KEY_UP,     10'd333, 1'b1, 2'd0, 10'd0,   10'd0},
        '{OP_TICK,       10'd0,   1'b1, 2'd1, 10'd1,   10'd0},
        '{OP_FOCUS_LOST, 10'd0,   1'b1, 2'd0, 10'd0,   10'd0},
        '{OP_TICK,       10'd0,   1'b1, 2'd0, 10'd0,   10'd0}
    };

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata   = '0;
    logic [OP_W-1:0]       s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [DATA_W-1:0]     m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    key_typematic_repeat DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // model of the slot table and the registers
    bit               held      [SLOTS_DEF];
    logic [KEY_W-1:0] held_key  [SLOTS_DEF];
    bit               auto_rpt  [SLOTS_DEF];
    logic [CNT_W-1:0] ticks_left[SLOTS_DEF];
    logic [CNT_W-1:0] cur_delay;
    logic [CNT_W-1:0] cur_period;
    logic [KEY_W-1:0] blocked   [4];

    rep_t fired_now[$];
    rep_t pending_repeats[$];
    int   mismatches = 0;
    int   cycles     = 0;
    bit   quiet      = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) cycles <= cycles + 1;

    initial begin : watchdog
        while (cycles < TIMEOUT_CYCLES) @(posedge aclk);
        $display("timeout after %0d cycles, %0d repeat words outstanding",
                 cycles, pending_repeats.size());
        $display("Some tests failed");
        $finish;
    end

    function automatic bit key_allowed(input logic [KEY_W-1:0] k);
        return k < KEY_LIMIT_DEF && k != blocked[0] && k != blocked[1]
            && k != blocked[2] && k != blocked[3];
    endfunction

    function automatic int slot_of(input logic [KEY_W-1:0] k);
        for (int i = 0; i < SLOTS_DEF; i++)
            if (held[i] && held_key[i] == k) return i;
        return -1;
    endfunction

    task automatic advance_typematic(input op_t op, input logic [KEY_W-1:0] k);
        int s;
        fired_now.delete();
        case (op)
            OP_KEY_DOWN: begin
                if (key_allowed(k)) begin
                    s = slot_of(k);
                    if (s < 0) begin
                        for (int i = SLOTS_DEF - 1; i >= 0; i--)
                            if (!held[i]) s = i;
                        // table full: the key down is dropped
                        if (s >= 0) begin
                            held[s]       = 1'b1;
                            held_key[s]   = k;
                            auto_rpt[s]   = 1'b0;
                            ticks_left[s] = cur_delay;
                        end
                    end else if (!auto_rpt[s]) begin
                        ticks_left[s] = cur_delay;
                    end
                end
            end
            OP_KEY_UP: begin
                s = slot_of(k);
                if (s >= 0) begin
                    held[s]     = 1'b0;
                    auto_rpt[s] = 1'b0;
                end
            end
            OP_FOCUS_LOST: begin
                for (int i = 0; i < SLOTS_DEF; i++) begin
                    held[i]       = 1'b0;
                    auto_rpt[i]   = 1'b0;
                    held_key[i]   = '0;
                    ticks_left[i] = '0;
                end
            end
            default: begin
                for (int i = 0; i < SLOTS_DEF; i++) begin
                    if (held[i]) begin
                        if (ticks_left[i] > 1) begin
                            ticks_left[i] = ticks_left[i] - 1'b1;
                        end else begin
                            ticks_left[i] = cur_period;
                            if (!auto_rpt[i]) auto_rpt[i] = 1'b1;
                            else fired_now.push_back('{held_key[i], 1'b0});
                        end
                    end
                end
                if (fired_now.size() > 0) fired_now[fired_now.size() - 1].last = 1'b1;
            end
        endcase
    endtask

    task automatic send_event(input op_t op, input logic [KEY_W-1:0] k, input bit typed,
                              input int n, input logic [KEY_W-1:0] k0,
                              input logic [KEY_W-1:0] k1);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'b0, k};
        do @(posedge aclk); while (!s_tready);
        advance_typematic(op, k);
        if (typed) begin
            if (n == 1) pending_repeats.push_back('{k0, 1'b1});
            if (n == 2) begin
                pending_repeats.push_back('{k0, 1'b0});
                pending_repeats.push_back('{k1, 1'b1});
            end
        end else begin
            foreach (fired_now[i]) pending_repeats.push_back(fired_now[i]);
        end
    endtask

    task automatic drain_events();
        s_tvalid <= 1'b0;
        while (pending_repeats.size() != 0) @(posedge aclk);
        // events that fire nothing may still be walking the ring
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_DELAY:  cur_delay  = val;
            CFG_PERIOD: cur_period = val;
            CFG_EXCL_A: blocked[0] = val[KEY_W-1:0];
            CFG_EXCL_B: blocked[1] = val[KEY_W-1:0];
            CFG_EXCL_C: blocked[2] = val[KEY_W-1:0];
            default:    blocked[3] = val[KEY_W-1:0];
        endcase
    endtask

    task automatic set_timing(input logic [CNT_W-1:0] dly, input logic [CNT_W-1:0] per,
                              input logic [KEY_W-1:0] ea, input logic [KEY_W-1:0] eb,
                              input logic [KEY_W-1:0] ec, input logic [KEY_W-1:0] ed);
        drain_events();
        write_reg(CFG_DELAY, dly);
        write_reg(CFG_PERIOD, per);
        // upper data bits are junk, only the low key bits count
        write_reg(CFG_EXCL_A, {6'($urandom_range(0, 63)), ea});
        write_reg(CFG_EXCL_B, {6'($urandom_range(0, 63)), eb});
        write_reg(CFG_EXCL_C, {6'($urandom_range(0, 63)), ec});
        write_reg(CFG_EXCL_D, {6'($urandom_range(0, 63)), ed});
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int count, input bit fill);
        op_t              op;
        logic [KEY_W-1:0] k;
        int               r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (fill && i < 18) op = OP_KEY_DOWN;
            else if (r < 45)    op = OP_KEY_DOWN;
            else if (r < 57)    op = OP_KEY_UP;
            else if (r < 60)    op = OP_FOCUS_LOST;
            else                op = OP_TICK;
            // mostly a small key pool so downs and ups meet, sometimes any code
            if (fill && i < 18)
                k = 10'(40 + i);
            else if (op inside {OP_KEY_DOWN, OP_KEY_UP} && $urandom_range(0, 3) != 0)
                k = 10'($urandom_range(0, 23));
            else
                k = 10'($urandom_range(0, 1023));
            send_event(op, k, 1'b0, 0, '0, '0);
        end
    endtask

    // receiver stalls
    initial begin
        forever begin
            if (quiet || $urandom_range(0, 2) != 0) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end else begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : check_repeats
        rep_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_repeats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected repeat word: key %0d last %0b", m_tdata, m_tlast);
            end else begin
                want = pending_repeats.pop_front();
                if (m_tdata !== {6'b0, want.key} || m_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("repeat mismatch: expected key %0d last %0b, got key %0d last %0b",
                                 want.key, want.last, m_tdata, m_tlast);
                end
            end
        end
    end

    initial begin : stimulus
        row_t row;
        for (int i = 0; i < SLOTS_DEF; i++) begin
            held[i]       = 1'b0;
            auto_rpt[i]   = 1'b0;
            held_key[i]   = '0;
            ticks_left[i] = '0;
        end
        cur_delay  = DELAY_RST;
        cur_period = PERIOD_RST;
        for (int i = 0; i < 4; i++) blocked[i] = EXCLUDED_RST;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < ROWS; r++) begin
            if (r == DEFAULT_ROWS) set_timing(16'd2, 16'd1, 10'd0, 10'd779, 10'd1023, 10'd500);
            row = SCRIPT[r];
            send_event(row.op, row.key, row.typed, int'(row.n), row.k0, row.k1);
        end

        // zero delay and period behave as one
        set_timing(16'd0, 16'd0, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
        run_phase(24, 1'b0);

        set_timing(16'd3, 16'd2, 10'($urandom_range(0, 23)), 10'($urandom_range(0, 23)),
                   10'($urandom_range(0, 23)), 10'($urandom_range(0, 23)));
        run_phase(26, 1'b1);

        set_timing(16'hFFFF, 16'hFFFF, 10'd0, 10'd1, 10'd2, 10'd3);
        run_phase(10, 1'b0);

        set_timing(16'($urandom_range(1, 4)), 16'($urandom_range(1, 3)),
                   10'($urandom_range(0, 1023)), 10'($urandom_range(0, 23)), 10'd779, 10'd780);
        run_phase(22, 1'b0);

        quiet = 1'b1;
        set_timing(16'd2, 16'd1, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
        run_phase(22, 1'b0);

        drain_events();
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
